// ===== rtl/lgc_pkg.sv =====
// ----------------------------------------------------------------------------
// lgc_pkg
// Shared types, codes and constants of the life grid census block.
// ----------------------------------------------------------------------------
package lgc_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  localparam int DIM_W     = 7;
  localparam int ROW_W     = 6;
  localparam int COL_W     = 6;
  localparam int CNT_W     = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [DIM_W-1:0] GRID_ROWS_RST = 7'd64;
  localparam logic [DIM_W-1:0] GRID_COLS_RST = 7'd64;

  typedef enum logic [1:0] {
    OP_SET_ALIVE = 2'd0,
    OP_SET_DEAD  = 2'd1,
    OP_READ      = 2'd2,
    OP_CENSUS    = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_ROWS  = 2'd0,
    CFG_GRID_COLS  = 2'd1,
    CFG_WRAP_EDGES = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SEL_UP   = 2'd0,
    SEL_MID  = 2'd1,
    SEL_DOWN = 2'd2
  } row_sel_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_APPLY,
    ST_MID,
    ST_DOWN,
    ST_SUM
  } state_t;

  typedef struct packed {
    logic     clear_we;
    logic     capture;
    row_sel_t rd_sel;
    logic     cnt_en;
    row_sel_t cnt_sel;
    logic     apply;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic census;
  } sts_t;

endpackage

// ===== rtl/lgc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lgc_ctrl
// Sequencer: clearing pass after reset, then per item the row reads,
// read-modify-write or three-row neighbour count.
// ----------------------------------------------------------------------------
module lgc_ctrl
  import lgc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_FETCH;
      end
      ST_FETCH: begin
        state_next = sts.census ? ST_MID : ST_APPLY;
      end
      ST_APPLY: state_next = ST_IDLE;
      ST_MID:   state_next = ST_DOWN;
      ST_DOWN:  state_next = ST_SUM;
      ST_SUM:   state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.rd_sel  = SEL_MID;
    cmd.cnt_sel = SEL_MID;
    busy        = 1'b1;
    case (state)
      ST_CLEAR: cmd.clear_we = 1'b1;
      ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      ST_FETCH: cmd.rd_sel = sts.census ? SEL_UP : SEL_MID;
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        cmd.finish = 1'b1;
      end
      ST_MID: begin
        cmd.rd_sel  = SEL_MID;
        cmd.cnt_en  = 1'b1;
        cmd.cnt_sel = SEL_UP;
      end
      ST_DOWN: begin
        cmd.rd_sel  = SEL_DOWN;
        cmd.cnt_en  = 1'b1;
        cmd.cnt_sel = SEL_MID;
      end
      ST_SUM: begin
        cmd.cnt_en  = 1'b1;
        cmd.cnt_sel = SEL_DOWN;
        cmd.finish  = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

// ===== rtl/lgc_datapath.sv =====
// ----------------------------------------------------------------------------
// lgc_datapath
// Grid row memory, configuration registers, neighbour addressing with
// optional wraparound, neighbour accumulator and result registers.
// ----------------------------------------------------------------------------
module lgc_datapath
  import lgc_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic [1:0]           opcode,
  input  logic [ROW_W-1:0]     row_index,
  input  logic [COL_W-1:0]     col_index,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  output logic                 done,
  output logic                 cell_alive,
  output logic [CNT_W-1:0]     live_neighbours,
  output logic                 in_range
);

  localparam int RA = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CA = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_COLS-1:0] rdata;
  logic [MAX_COLS-1:0] wdata;
  logic [RA-1:0]       raddr;
  logic [RA-1:0]       waddr;
  logic                we;
  logic [RA-1:0]       clr_addr;

  logic [DIM_W-1:0] grid_rows;
  logic [DIM_W-1:0] grid_cols;
  logic             wrap_edges;

  op_t              op_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic [CNT_W-1:0] acc;

  logic [DIM_W-1:0] nr, nc;
  logic [DIM_W-1:0] row7, col7, up_row, dn_row, cm_col, cp_col, dn_sum, cp_sum;
  logic             ok, up_ok, dn_ok, cm_ok, cp_ok, dn_last, cp_last;
  logic [CA-1:0]    c_a, cm_a, cp_a;
  logic             row_ok, tm, tc, tp;
  logic [1:0]       terms;
  logic [CNT_W-1:0] acc_sum;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows  <= GRID_ROWS_RST;
      grid_cols  <= GRID_COLS_RST;
      wrap_edges <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GRID_ROWS:  grid_rows  <= cfg_data;
        CFG_GRID_COLS:  grid_cols  <= cfg_data;
        CFG_WRAP_EDGES: wrap_edges <= cfg_data[0];
        default:        wrap_edges <= wrap_edges;
      endcase
    end
  end

  assign nr = (32'(grid_rows) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : grid_rows;
  assign nc = (32'(grid_cols) > MAX_COLS) ? DIM_W'(MAX_COLS) : grid_cols;

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= op_t'(opcode);
      row_q <= row_index;
      col_q <= col_index;
    end
  end

  // neighbour coordinates
  assign row7    = {1'b0, row_q};
  assign col7    = {1'b0, col_q};
  assign ok      = (row7 < nr) && (col7 < nc);
  assign up_ok   = (row_q != '0) || wrap_edges;
  assign up_row  = (row_q == '0) ? nr - 7'd1 : row7 - 7'd1;
  assign dn_sum  = row7 + 7'd1;
  assign dn_last = (dn_sum == nr);
  assign dn_ok   = !dn_last || wrap_edges;
  assign dn_row  = dn_last ? '0 : dn_sum;
  assign cm_ok   = (col_q != '0) || wrap_edges;
  assign cm_col  = (col_q == '0) ? nc - 7'd1 : col7 - 7'd1;
  assign cp_sum  = col7 + 7'd1;
  assign cp_last = (cp_sum == nc);
  assign cp_ok   = !cp_last || wrap_edges;
  assign cp_col  = cp_last ? '0 : cp_sum;
  assign c_a     = CA'(col_q);
  assign cm_a    = CA'(cm_col);
  assign cp_a    = CA'(cp_col);

  // memory ports
  always_comb begin
    case (cmd.rd_sel)
      SEL_UP:   raddr = RA'(up_row);
      SEL_DOWN: raddr = RA'(dn_row);
      default:  raddr = RA'(row_q);
    endcase
  end

  always_comb begin
    wdata = rdata;
    wdata[c_a] = (op_q == OP_SET_ALIVE);
    waddr = RA'(row_q);
    we    = cmd.apply && ok && (op_q == OP_SET_ALIVE || op_q == OP_SET_DEAD);
    if (cmd.clear_we) begin
      wdata = '0;
      waddr = clr_addr;
      we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_we) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign sts.clear_last = (clr_addr == RA'(MAX_ROWS - 1));
  assign sts.census     = (op_q == OP_CENSUS);

  // neighbour count of one row word
  always_comb begin
    case (cmd.cnt_sel)
      SEL_UP:   row_ok = up_ok;
      SEL_DOWN: row_ok = dn_ok;
      default:  row_ok = 1'b1;
    endcase
    tm = rdata[cm_a] & cm_ok;
    tc = rdata[c_a] & (cmd.cnt_sel != SEL_MID);
    tp = rdata[cp_a] & cp_ok;
    terms = (row_ok && ok) ? ({1'b0, tm} + {1'b0, tc} + {1'b0, tp}) : 2'd0;
  end

  assign acc_sum = acc + {2'b00, terms};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      acc <= '0;
    end else if (cmd.cnt_en) begin
      acc <= acc_sum;
    end
  end

  // results
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      cell_alive      <= (op_q == OP_READ) && ok && rdata[c_a];
      live_neighbours <= (op_q == OP_CENSUS) ? acc_sum : '0;
      in_range        <= ok;
    end
  end

endmodule

// ===== rtl/life_grid_census_core.sv =====
// ----------------------------------------------------------------------------
// life_grid_census_core
// Bit grid of cells with set, clear, read and eight-neighbour census items.
// ----------------------------------------------------------------------------
// Sequence: a census item runs FETCH, MID, DOWN and SUM, and a set, clear or
// read item runs FETCH and APPLY; done is registered from the last state.
// Items: a new item is taken only in IDLE, once the last one ends; the grid
// memory has one read port, so a census reads its three rows one per cycle.
// Reset: synchronous; busy then stays high while the grid is cleared row by
// row. Config writes always taken; done is high one cycle per item.
// ----------------------------------------------------------------------------
module life_grid_census_core
  import lgc_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           opcode,
  input  logic [ROW_W-1:0]     row_index,
  input  logic [COL_W-1:0]     col_index,
  output logic                 done,
  output logic                 cell_alive,
  output logic [CNT_W-1:0]     live_neighbours,
  output logic                 in_range,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  lgc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  lgc_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .opcode          (opcode),
    .row_index       (row_index),
    .col_index       (col_index),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .done            (done),
    .cell_alive      (cell_alive),
    .live_neighbours (live_neighbours),
    .in_range        (in_range)
  );

endmodule
